// ===== rtl/tadf_pkg.sv =====
// shared types and constants for the triangle drag force block
`default_nettype none
package tadf_pkg;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned RegW = 31;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegRadius = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInvH = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDensF = 3'd2;
  localparam logic [CfgIdxW-1:0] RegViscF = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDensB = 3'd4;
  localparam logic [CfgIdxW-1:0] RegViscB = 3'd5;

  localparam logic [RegW-1:0] RstRadius = 31'd655360;
  localparam logic [RegW-1:0] RstInvH = 31'd9362;
  localparam logic [RegW-1:0] RstDensF = 31'd65536;
  localparam logic [RegW-1:0] RstViscF = 31'd65536;
  localparam logic [RegW-1:0] RstDensB = 31'd32768;
  localparam logic [RegW-1:0] RstViscB = 31'd32768;

  // multiplier operand selects
  typedef enum logic [4:0] {
    MulPx, MulPy, MulPz, MulHInv, MulXX, MulSDf, MulSVf, MulSDb, MulSVb,
    MulNx, MulNy, MulNz, MulVnVn, MulDens, MulArea, MulScN, MulVnN, MulDA, MulDV
  } mul_op_e;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdSqrtStart, CmdAltitude, CmdMul, CmdSelFace, CmdDiff, CmdSum, CmdPutOut
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e    cmd;
    mul_op_e    mop;
    logic [1:0] lane;
  } dp_ctrl_t;

  typedef struct packed {
    logic sqrt_done;
    logic above;
    logic nonpos;
    logic in_air;
    logic mode;
  } dp_stat_t;

  typedef enum logic [4:0] {
    StIdle, StSq, StSqrt, StAlt, StX, StXX, StScale, StOutside,
    StDot, StDotSum, StVv, StDen, StAr, StLane, StScN, StVnN, StDiff, StDA, StDV,
    StSum, StOut, StWait
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/tadf_if.sv =====
// valid/ready channel carrying one word
`default_nettype none
interface tadf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tadf_ctrl.sv =====
// sequencer that steps the shared datapath through one item
`default_nettype none
module tadf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tadf_pkg::dp_stat_t stat_i,
  output tadf_pkg::dp_ctrl_t ctrl_o
);
  import tadf_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] lane_q, lane_d;
  logic       ov_q, ov_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lane_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign in_ready_o  = (state_q == StIdle);

  // next state and commands
  always_comb begin
    state_d = state_q;
    lane_d  = lane_q;
    ov_d    = ov_q && !out_ready_i;
    ctrl_o  = '{cmd: CmdNone, mop: MulPx, lane: lane_q};
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ctrl_o.cmd = CmdLoad;
          lane_d = '0;
          state_d = StSq;
        end
      end
      StSq: begin
        if (stat_i.mode) begin
          state_d = stat_i.in_air ? StDot : StIdle;
        end else begin
          ctrl_o.cmd = CmdMul;
          ctrl_o.mop = mul_op_e'(MulPx + lane_q);
          lane_d = lane_q + 2'd1;
          if (lane_q == 2'd2) begin
            state_d = StSqrt;
          end
        end
      end
      StSqrt: begin
        ctrl_o.cmd = CmdSqrtStart;
        state_d = StWait;
      end
      StWait: begin
        if (stat_i.sqrt_done) begin
          state_d = StAlt;
        end
      end
      StAlt: begin
        ctrl_o.cmd = CmdAltitude;
        state_d = StX;
      end
      StX: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = MulHInv;
        state_d = StXX;
      end
      StXX: begin
        if (stat_i.above) begin
          state_d = StOutside;
        end else begin
          ctrl_o.cmd = CmdMul;
          ctrl_o.mop = MulXX;
          lane_d = '0;
          state_d = StScale;
        end
      end
      StScale: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = mul_op_e'(MulSDf + {2'b00, lane_q});
        if (lane_q == 2'd3) begin
          state_d = StIdle;
        end else begin
          lane_d = lane_q + 2'd1;
        end
      end
      StOutside: begin
        ctrl_o.cmd = CmdAltitude;
        state_d = StIdle;
      end
      StDot: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = mul_op_e'(MulNx + lane_q);
        lane_d = lane_q + 2'd1;
        if (lane_q == 2'd2) begin
          state_d = StDotSum;
        end
      end
      StDotSum: begin
        ctrl_o.cmd = CmdSelFace;
        state_d = StVv;
      end
      StVv: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = MulVnVn;
        state_d = StDen;
      end
      StDen: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = MulDens;
        state_d = StAr;
      end
      StAr: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = MulArea;
        lane_d = '0;
        state_d = StScN;
      end
      StScN: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = MulScN;
        state_d = StVnN;
      end
      StVnN: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = MulVnN;
        state_d = StDiff;
      end
      StDiff: begin
        ctrl_o.cmd = CmdDiff;
        state_d = StDA;
      end
      StDA: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = MulDA;
        state_d = StDV;
      end
      StDV: begin
        ctrl_o.cmd = CmdMul;
        ctrl_o.mop = MulDV;
        state_d = StSum;
      end
      StSum: begin
        ctrl_o.cmd = CmdSum;
        if (lane_q == 2'd2) begin
          state_d = StOut;
        end else begin
          lane_d = lane_q + 2'd1;
          state_d = StScN;
        end
      end
      StOut: begin
        if (!ov_q) begin
          ctrl_o.cmd = CmdPutOut;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      StLane: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/tadf_dp.sv =====
// datapath: config registers, state, one shared multiplier, bitwise square root
`default_nettype none
module tadf_dp #(
  parameter int unsigned FracBits = tadf_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tadf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tadf_pkg::RegW-1:0]     cfg_data_i,
  input  logic                          in_mode_i,
  input  logic signed [31:0]            in_vec_i [3],
  input  logic signed [31:0]            in_vel_i [3],
  input  logic [tadf_pkg::RegW-1:0]     in_area_i,
  input  tadf_pkg::dp_ctrl_t            ctrl_i,
  output tadf_pkg::dp_stat_t            stat_o,
  output logic signed [31:0]            force_o [3],
  output logic                          front_o
);
  import tadf_pkg::*;

  localparam logic signed [33:0] Max32 = 34'sd2147483647;
  localparam logic signed [33:0] Min32 = -34'sd2147483648;
  localparam logic [63:0] QOne = 64'd1 << FracBits;

  logic [RegW-1:0] regs_q [NumRegs];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] sdf_q, svf_q, sdb_q, svb_q;
  logic inside_q;
  logic mode_q;
  logic signed [31:0] vec_q [3];
  logic [RegW-1:0] area_q;

  logic [65:0] acc_q;        // sum of squares
  logic signed [65:0] dot_q; // exact dot product
  logic signed [33:0] h_q;
  logic [63:0] x_q, s_q;
  logic signed [31:0] vn_q, dens_q, visc_q, sc_q, vnn_q, d_q, da_q;
  logic signed [32:0] dyn_q; // negated term can reach +2^31
  logic front_q;
  logic signed [31:0] frc_q [3];
  logic signed [31:0] force_q [3];
  logic fq_front_q;

  // square root unit, two radicand bits per cycle
  logic [65:0] rem_q;
  logic [32:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q;

  // operand select for the shared 34x34 multiplier
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [31:0] l_vel, l_n;
  always_comb begin
    l_vel = vel_q[ctrl_i.lane];
    l_n   = vec_q[ctrl_i.lane];
    ma = '0;
    mb = '0;
    case (ctrl_i.mop)
      MulPx, MulPy, MulPz: begin ma = 34'(l_n); mb = 34'(l_n); end
      MulHInv: begin ma = h_q; mb = {3'd0, regs_q[RegInvH]}; end
      MulXX:   begin ma = {1'b0, x_q[32:0]}; mb = {1'b0, x_q[32:0]}; end
      MulSDf:  begin ma = {1'b0, s_q[32:0]}; mb = {3'd0, regs_q[RegDensF]}; end
      MulSVf:  begin ma = {1'b0, s_q[32:0]}; mb = {3'd0, regs_q[RegViscF]}; end
      MulSDb:  begin ma = {1'b0, s_q[32:0]}; mb = {3'd0, regs_q[RegDensB]}; end
      MulSVb:  begin ma = {1'b0, s_q[32:0]}; mb = {3'd0, regs_q[RegViscB]}; end
      MulNx, MulNy, MulNz: begin ma = 34'(l_vel); mb = 34'(l_n); end
      MulVnVn: begin ma = 34'(vn_q); mb = 34'(vn_q); end
      MulDens: begin ma = 34'(sc_q); mb = 34'(dens_q); end
      MulArea: begin ma = 34'(sc_q); mb = {3'd0, area_q}; end
      MulScN:  begin ma = 34'(sc_q); mb = 34'(l_n); end
      MulVnN:  begin ma = 34'(vn_q); mb = 34'(l_n); end
      MulDA:   begin ma = 34'(d_q); mb = {3'd0, area_q}; end
      MulDV:   begin ma = 34'(da_q); mb = 34'(visc_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = ma * mb;

  // floored product saturated to 32 bits
  logic signed [67:0] pfl;
  logic signed [31:0] psat;
  assign pfl = prod >>> FracBits;
  always_comb begin
    if (pfl > 68'(Max32)) psat = Max32[31:0];
    else if (pfl < 68'(Min32)) psat = Min32[31:0];
    else psat = pfl[31:0];
  end

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > Max32) return Max32[31:0];
    if (v < Min32) return Min32[31:0];
    return v[31:0];
  endfunction

  logic signed [65:0] vn_full;
  logic signed [31:0] vn_sat;
  assign vn_full = dot_q >>> FracBits;
  always_comb begin
    if (vn_full > 66'(Max32)) vn_sat = Max32[31:0];
    else if (vn_full < 66'(Min32)) vn_sat = Min32[31:0];
    else vn_sat = vn_full[31:0];
  end

  logic signed [31:0] dens_sel, visc_sel;
  assign dens_sel = (vn_sat >= 0) ? sdf_q : sdb_q;
  assign visc_sel = (vn_sat >= 0) ? svf_q : svb_q;

  // square root step, radicand below 2^64
  logic [65:0] trial;
  logic [65:0] rem_sh;
  assign rem_sh = {rem_q[63:0], acc_q[63:62]};
  assign trial  = {31'd0, root_q, 2'b01};

  logic [63:0] x_d;
  assign x_d = 64'(prod[67:FracBits]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[RegRadius] <= RstRadius;
      regs_q[RegInvH]   <= RstInvH;
      regs_q[RegDensF]  <= RstDensF;
      regs_q[RegViscF]  <= RstViscF;
      regs_q[RegDensB]  <= RstDensB;
      regs_q[RegViscB]  <= RstViscB;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumRegs))) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q    <= '{default: '0};
      sdf_q    <= '0;
      svf_q    <= '0;
      sdb_q    <= '0;
      svb_q    <= '0;
      inside_q <= 1'b0;
      busy_q   <= 1'b0;
    end else begin
      if (ctrl_i.cmd == CmdLoad && !in_mode_i) vel_q <= in_vel_i;
      if (ctrl_i.cmd == CmdSqrtStart) busy_q <= 1'b1;
      else if (busy_q && cnt_q == 6'd32) busy_q <= 1'b0;
      if (ctrl_i.cmd == CmdAltitude && mode_q == 1'b0 && x_q > QOne && h_q > 0) begin
        inside_q <= 1'b0;
        sdf_q <= '0; svf_q <= '0; sdb_q <= '0; svb_q <= '0;
      end
      if (ctrl_i.cmd == CmdMul) begin
        case (ctrl_i.mop)
          MulSDf: begin sdf_q <= prod[31+FracBits:FracBits]; inside_q <= 1'b1; end
          MulSVf: svf_q <= prod[31+FracBits:FracBits];
          MulSDb: sdb_q <= prod[31+FracBits:FracBits];
          MulSVb: svb_q <= prod[31+FracBits:FracBits];
          default: ;
        endcase
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CmdLoad: begin
        mode_q <= in_mode_i;
        vec_q  <= in_vec_i;
        area_q <= in_area_i;
        acc_q  <= '0;
        dot_q  <= '0;
      end
      CmdSqrtStart: begin
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end
      CmdAltitude: ;
      CmdSelFace: begin
        vn_q    <= vn_sat;
        front_q <= (vn_sat >= 0);
        dens_q  <= dens_sel;
        visc_q  <= visc_sel;
      end
      CmdDiff: d_q <= sat34(34'(vnn_q) - 34'(vel_q[ctrl_i.lane]));
      CmdSum: frc_q[ctrl_i.lane] <= sat34(34'(dyn_q) + 34'(da_q));
      CmdPutOut: begin
        force_q    <= frc_q;
        fq_front_q <= front_q;
      end
      CmdMul: begin
        case (ctrl_i.mop)
          MulPx, MulPy, MulPz: acc_q <= acc_q + prod[65:0];
          MulHInv: x_q <= (h_q > 0) ? x_d : 64'd0;
          MulXX: s_q <= QOne - 64'(prod[67:FracBits]);
          MulNx, MulNy, MulNz: dot_q <= dot_q + prod[65:0];
          MulVnVn: sc_q <= psat;
          MulDens: sc_q <= psat;
          MulArea: sc_q <= psat;
          MulScN: dyn_q <= -33'(psat);
          MulVnN: vnn_q <= psat;
          MulDA: da_q <= psat;
          MulDV: da_q <= psat;
          default: ;
        endcase
      end
      default: ;
    endcase
    // altitude after the root settles
    if (ctrl_i.cmd == CmdAltitude) h_q <= 34'(root_q) - 34'(regs_q[RegRadius]);
    // one root bit per cycle
    if (busy_q && cnt_q != 6'd32) begin
      acc_q <= {acc_q[63:0], 2'b00};
      cnt_q <= cnt_q + 6'd1;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[31:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[31:0], 1'b0};
      end
    end
  end

  assign stat_o.sqrt_done = busy_q && cnt_q == 6'd32;
  assign stat_o.above  = (h_q > 0) && (x_q > QOne);
  assign stat_o.nonpos = !(h_q > 0);
  assign stat_o.in_air = inside_q;
  assign stat_o.mode   = mode_q;
  assign force_o = force_q;
  assign front_o = fq_front_q;
endmodule
`default_nettype wire

// ===== rtl/triangle_aero_drag_force.sv =====
// top level of the triangle drag force block
// One item at a time through a shared 34x34 multiplier and a one-bit-per-cycle
// square root. A block word runs the root and then the altitude test, and skips
// the scaling when it lands above the atmosphere. A triangle word outside the air
// ends without a force; otherwise it waits in its output state while the
// previous force still sits unaccepted in the output register, including the
// cycle in which that register frees.
// A finished force waits in its output register while the next word is taken in.
`default_nettype none
module triangle_aero_drag_force #(
  parameter int unsigned FracBits = tadf_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tadf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tadf_pkg::RegW-1:0]     cfg_data_i,
  tadf_if.sink                          in_if,
  tadf_if.source                        out_if
);
  import tadf_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic signed [31:0] vec [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] frc [3];

  assign vec = '{in_if.data.vec_x, in_if.data.vec_y, in_if.data.vec_z};
  assign vel = '{in_if.data.vel_x, in_if.data.vel_y, in_if.data.vel_z};

  // sequencer
  tadf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  // datapath
  tadf_dp #(.FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_mode_i(in_if.data.mode), .in_vec_i(vec), .in_vel_i(vel),
    .in_area_i(in_if.data.area), .ctrl_i(ctrl), .stat_o(stat),
    .force_o(frc), .front_o(out_if.data.front_facing)
  );

  assign out_if.data.force_x = frc[0];
  assign out_if.data.force_y = frc[1];
  assign out_if.data.force_z = frc[2];
endmodule
`default_nettype wire
